// ===== design/smpq_pkg.sv =====
`default_nettype none
package smpq_pkg;

  localparam int unsigned KeyBits = 32;
  localparam int unsigned TagBits = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [KeyBits-1:0] new_key;
    logic [TagBits-1:0] new_payload;
  } smpq_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [KeyBits-1:0] out_key;
    logic [TagBits-1:0] out_payload;
    logic               is_empty;
    logic               is_full;
  } smpq_rsp_t;

  typedef struct packed {
    logic [KeyBits-1:0] key;
    logic [TagBits-1:0] tag;
  } smpq_entry_t;

  // Broadcast to every cell in the chain
  typedef struct packed {
    logic        ins;
    logic        rem;
    smpq_entry_t entry;
  } smpq_cmd_t;

endpackage
`default_nettype wire

// ===== design/sorted_min_priority_queue.sv =====
// Channel   | Ports              | Handshake
// ----------+--------------------+---------------------------------------------
// request   | start, req_i       | taken at a rising edge with start high, busy low
// response  | done_o, rsp_o      | valid for the one cycle done_o is high
//
// One request per cycle: busy stays low, every request is taken.
// Each response appears in the cycle after its request is taken; the whole chain of cells
// updates at that same edge (compare in every cell, shift to a neighbor).
// Reset empties the queue: cell valid flags clear, entries are don't-care.
// The receiver cannot stall, so no response is ever held back.
`default_nettype none
module sorted_min_priority_queue
  import smpq_pkg::*;
#(
  parameter int unsigned SLOTS = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire smpq_req_t req_i,
  output logic           done_o,
  output smpq_rsp_t      rsp_o
);

  // One slot of the ring is never used, so the chain holds SLOTS-1 cells.
  // Cell 0 is the head and holds the smallest key.
  localparam int unsigned Cells = SLOTS - 1;

  smpq_entry_t entry_w [Cells];
  logic [Cells-1:0] valid_w;
  logic [Cells-1:0] take_w;
  smpq_cmd_t   cmd;
  logic        accept;
  logic        q_full, q_empty;

  logic                 done_q;
  logic [1:0]           status_q;
  logic [KeyBits-1:0]   key_q;
  logic [TagBits-1:0]   tag_q;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign q_empty = !valid_w[0];
  assign q_full  = valid_w[Cells-1];

  // Refused operations leave the chain untouched.
  always_comb begin
    cmd.ins         = accept && (req_i.operation == OP_INSERT) && !q_full;
    cmd.rem         = accept && (req_i.operation == OP_REMOVE) && !q_empty;
    cmd.entry.key   = req_i.new_key;
    cmd.entry.tag   = req_i.new_payload;
  end

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    smpq_entry_t prev_entry, next_entry;
    logic        prev_valid, prev_take, next_valid;

    if (i == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_valid = 1'b0;
      assign prev_take  = 1'b0;
    end else begin : g_mid
      assign prev_entry = entry_w[i-1];
      assign prev_valid = valid_w[i-1];
      assign prev_take  = take_w[i-1];
    end

    if (i == Cells - 1) begin : g_tail
      assign next_entry = '0;
      assign next_valid = 1'b0;
    end else begin : g_body
      assign next_entry = entry_w[i+1];
      assign next_valid = valid_w[i+1];
    end

    smpq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_entry_i (prev_entry),
      .prev_valid_i (prev_valid),
      .prev_take_i  (prev_take),
      .next_entry_i (next_entry),
      .next_valid_i (next_valid),
      .entry_o      (entry_w[i]),
      .valid_o      (valid_w[i]),
      .take_o       (take_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  // Response payload; the head entry is captured on a successful remove.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (req_i.operation == OP_INSERT) begin
        status_q <= q_full ? ST_FULL : ST_DONE;
        key_q    <= '0;
        tag_q    <= '0;
      end else if (q_empty) begin
        status_q <= ST_EMPTY;
        key_q    <= '0;
        tag_q    <= '0;
      end else begin
        status_q <= ST_DONE;
        key_q    <= entry_w[0].key;
        tag_q    <= entry_w[0].tag;
      end
    end
  end

  // Flags come straight from the chain, which already holds the post-op state.
  assign done_o            = done_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.out_key     = key_q;
  assign rsp_o.out_payload = tag_q;
  assign rsp_o.is_empty    = q_empty;
  assign rsp_o.is_full     = q_full;

  // Occupied cells always form an unbroken run from the head.
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_w >> 1) & ~valid_w) == '0)
    else $error("cell chain has a hole");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("request without response");

  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FULL) |-> rsp_o.is_full)
    else $error("insert refused while not full");

  a_empty_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_EMPTY) |-> rsp_o.is_empty)
    else $error("remove refused while not empty");

  a_insert_fills_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> valid_w[0])
    else $error("insert left head empty");

endmodule
`default_nettype wire

// ===== design/smpq_cell.sv =====
`default_nettype none
module smpq_cell
  import smpq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire smpq_cmd_t   cmd_i,
  // lower neighbor (closer to the head)
  input  wire smpq_entry_t prev_entry_i,
  input  wire logic        prev_valid_i,
  input  wire logic        prev_take_i,
  // upper neighbor (closer to the tail)
  input  wire smpq_entry_t next_entry_i,
  input  wire logic        next_valid_i,
  output smpq_entry_t      entry_o,
  output logic             valid_o,
  output logic             take_o
);

  smpq_entry_t entry_q, entry_d;
  logic        valid_q, valid_d;

  // Cell sits at or beyond the insert point: empty, or key not below new key.
  assign take_o = !valid_q || (cmd_i.entry.key <= entry_q.key);

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (cmd_i.ins && take_o) begin
      if (prev_take_i) begin
        entry_d = prev_entry_i;
        valid_d = prev_valid_i;
      end else begin
        entry_d = cmd_i.entry;
        valid_d = 1'b1;
      end
    end else if (cmd_i.rem) begin
      entry_d = next_entry_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;

endmodule
`default_nettype wire

// ===== sim/sorted_min_priority_queue_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the sorted min-priority queue. A shadow ring of
// slots is kept here and updated for every request the block takes; the
// response that the shadow produces is queued and compared with the block's
// response when done_o marks it.
module sorted_min_priority_queue_test;
  import smpq_pkg::*;

  localparam int unsigned SLOTS    = 64;
  localparam int unsigned IDX_BITS = $clog2(SLOTS);
  localparam int unsigned CAPACITY = SLOTS - 1;     // one slot always stays unused
  localparam int unsigned N_ITEMS  = 1150;          // random part stops near here
  localparam int unsigned STALL_LIMIT = 1000;       // cycles with nothing taken or returned

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  logic      busy;
  smpq_req_t req_i  = '0;
  logic      done_o;
  smpq_rsp_t rsp_o;

  sorted_min_priority_queue #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  // 20 ns period
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the queue: ascending keys from ring_back up to ring_front.
  // ---------------------------------------------------------------------------
  smpq_entry_t         ring_slot [SLOTS];
  logic [IDX_BITS-1:0] ring_front = '0;   // insert side
  logic [IDX_BITS-1:0] ring_back  = '0;   // remove side, smallest key

  // Applies one request to the shadow and returns the response it must give.
  function automatic smpq_rsp_t sorted_queue_op(smpq_req_t r);
    smpq_rsp_t           rsp;
    logic [IDX_BITS-1:0] pos;
    logic [IDX_BITS-1:0] a;
    logic [IDX_BITS-1:0] b;
    logic [IDX_BITS-1:0] prev;
    logic [IDX_BITS-1:0] front_nxt;
    bit                  found;
    rsp       = '0;
    rsp.status = ST_DONE;
    front_nxt = ring_front + 1'b1;
    if (r.operation == OP_INSERT) begin
      if (front_nxt == ring_back) begin
        rsp.status = ST_FULL;
      end else begin
        // first entry from the back whose key is >= the new one; ties put
        // the new entry ahead, so the newest equal key leaves first
        pos   = ring_front;
        found = 1'b0;
        a     = ring_back;
        while (a != ring_front && !found) begin
          if (r.new_key <= ring_slot[a].key) begin
            pos   = a;
            found = 1'b1;
          end else begin
            a = a + 1'b1;
          end
        end
        // open the gap; index arithmetic wraps slot 0 onto the last slot
        b = ring_front;
        while (b != pos) begin
          prev         = b - 1'b1;
          ring_slot[b] = ring_slot[prev];
          b            = prev;
        end
        ring_slot[pos].key = r.new_key;
        ring_slot[pos].tag = r.new_payload;
        ring_front         = front_nxt;
      end
    end else begin
      if (ring_front == ring_back) begin
        rsp.status = ST_EMPTY;
      end else begin
        rsp.out_key     = ring_slot[ring_back].key;
        rsp.out_payload = ring_slot[ring_back].tag;
        ring_back       = ring_back + 1'b1;
      end
    end
    rsp.is_empty = (ring_front == ring_back);
    rsp.is_full  = ((ring_front + 1'b1) == ring_back);
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus backlog, filled up front. fill_level mirrors occupancy so that
  // fill and drain bursts can be shaped to hit full and empty exactly.
  // ---------------------------------------------------------------------------
  smpq_req_t   op_backlog[$];
  smpq_rsp_t   expected_rsp_q[$];
  int unsigned fill_level  = 0;
  int unsigned issued_cnt  = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned stall_cycles = 0;
  bit          req_taken   = 1'b0;

  task automatic add_request(logic op, logic [KeyBits-1:0] key, logic [TagBits-1:0] tag);
    smpq_req_t r;
    r.operation   = op;
    r.new_key     = key;
    r.new_payload = tag;
    op_backlog.push_back(r);
    if (op == OP_INSERT && fill_level < CAPACITY) fill_level++;
    if (op == OP_REMOVE && fill_level > 0) fill_level--;
  endtask

  // Mix of full-range, clustered (lots of ties), extreme and 1000..1031 keys
  function automatic logic [KeyBits-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 7);
      2: return $urandom_range(0, 1) ? {KeyBits{1'b1}} : {KeyBits{1'b0}};
      default: return $urandom_range(1000, 1031);
    endcase
  endfunction

  function automatic logic [TagBits-1:0] pick_tag();
    return TagBits'($urandom_range(0, (1 << TagBits) - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one request on the bus at a time, held until taken. About 37% of
  // slots idle, except for a run of requests sent back to back.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!start || req_taken)) begin
      if (op_backlog.size() > 0 &&
          ((issued_cnt >= 500 && issued_cnt < 700) || $urandom_range(0, 99) >= 37)) begin
        start <= 1'b1;
        req_i <= op_backlog.pop_front();
        issued_cnt++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check the response of this cycle, then predict for a request
  // taken at this edge. A response never belongs to the request taken at the
  // same edge, so the order here is safe.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    smpq_rsp_t want;
    if (!rst_ni) begin
      req_taken    = 1'b0;
      stall_cycles = 0;
    end else begin
      if (done_o) begin
        if (expected_rsp_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: response with no request outstanding: status %0d key %h tag %h",
                   $time, rsp_o.status, rsp_o.out_key, rsp_o.out_payload);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_o.status !== want.status || rsp_o.out_key !== want.out_key ||
              rsp_o.out_payload !== want.out_payload || rsp_o.is_empty !== want.is_empty ||
              rsp_o.is_full !== want.is_full) begin
            mismatch_cnt++;
            // fields: status/key/tag/empty/full
            $display("%0t: expected %0d/%h/%h/%b/%b, got %0d/%h/%h/%b/%b",
                     $time, want.status, want.out_key, want.out_payload, want.is_empty,
                     want.is_full, rsp_o.status, rsp_o.out_key, rsp_o.out_payload,
                     rsp_o.is_empty, rsp_o.is_full);
          end
        end
      end

      req_taken = start && !busy;
      if (req_taken) expected_rsp_q.push_back(sorted_queue_op(req_i));

      // watchdog on cycles where neither side moves anything
      if (req_taken || done_o) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned k;
    int unsigned burst;
    for (k = 0; k < SLOTS; k++) ring_slot[k] = '0;

    // Directed: remove from an empty queue (payload fields are noise), key
    // and tag extremes, a run of equal keys that must leave newest first,
    // then drain and remove once more past empty.
    add_request(OP_REMOVE, {KeyBits{1'b1}}, {TagBits{1'b1}});
    add_request(OP_INSERT, {KeyBits{1'b1}}, {TagBits{1'b1}});
    add_request(OP_INSERT, '0, '0);
    add_request(OP_INSERT, 32'd5, 16'h0001);
    add_request(OP_INSERT, 32'd5, 16'h0002);
    add_request(OP_INSERT, 32'd5, 16'h0003);
    add_request(OP_INSERT, {KeyBits{1'b1}}, 16'hAAAA);
    add_request(OP_INSERT, '0, 16'h5555);
    add_request(OP_INSERT, 32'h8000_0000, 16'h8000);
    for (k = 0; k < 8; k++) add_request(OP_REMOVE, $urandom, pick_tag());
    add_request(OP_REMOVE, '0, '0);

    // Random: fill bursts run into full and push past it, drain bursts run
    // out past empty; in between, random mixes. Occupancy sweeps the whole
    // ring, so inserts shift entries across the wrap many times.
    while (op_backlog.size() < N_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          while (fill_level < CAPACITY) add_request(OP_INSERT, pick_key(), pick_tag());
          burst = $urandom_range(1, 3);
          for (k = 0; k < burst; k++) add_request(OP_INSERT, pick_key(), pick_tag());
        end
        2, 3: begin
          while (fill_level > 0) add_request(OP_REMOVE, $urandom, pick_tag());
          burst = $urandom_range(1, 3);
          for (k = 0; k < burst; k++) add_request(OP_REMOVE, $urandom, pick_tag());
        end
        default: begin
          burst = $urandom_range(10, 60);
          for (k = 0; k < burst; k++) begin
            if ($urandom_range(0, 99) < 55) add_request(OP_INSERT, pick_key(), pick_tag());
            else add_request(OP_REMOVE, $urandom, pick_tag());
          end
        end
      endcase
    end

    // reset held low, then released at a falling edge, away from the rising edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (op_backlog.size() > 0 || start) @(posedge clk_i);
    while (expected_rsp_q.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sorted_min_priority_queue.f =====
design/smpq_pkg.sv
design/smpq_cell.sv
design/sorted_min_priority_queue.sv
sim/sorted_min_priority_queue_test.sv
